@@ rtl/idafr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package idafr_pkg;

  localparam int MAX_IDS = 256;
  localparam int ID_W    = (MAX_IDS > 2) ? $clog2(MAX_IDS) : 1;
  localparam int CNT_W   = $clog2(MAX_IDS + 1);

  typedef enum logic [1:0] {
    ACT_ALLOC   = 2'd0,
    ACT_RELEASE = 2'd1,
    ACT_QUERY   = 2'd2,
    ACT_CLEAR   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_BAD  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] id;
  } in_item_t;

  typedef struct packed {
    logic [7:0] id_out;
    logic       live;
    logic [1:0] status;
  } out_item_t;

  // free list commands and status
  typedef struct packed {
    logic            push;
    logic [ID_W-1:0] push_id;
    logic            pop;
  } fl_cmd_t;

  typedef struct packed {
    logic            nonempty;
    logic [ID_W-1:0] head_id;
  } fl_stat_t;

  function automatic logic [ID_W-1:0] id8_to_addr(input logic [7:0] v);
    logic [ID_W+7:0] ext;
    ext = {{ID_W{1'b0}}, v};
    return ext[ID_W-1:0];
  endfunction

  function automatic logic [7:0] addr_to_id8(input logic [ID_W-1:0] v);
    logic [ID_W+7:0] ext;
    ext = {8'b0, v};
    return ext[7:0];
  endfunction

  // strict bound against the high-water count
  function automatic logic id_below(input logic [7:0] v, input logic [CNT_W-1:0] cnt);
    logic [CNT_W+7:0] a;
    logic [CNT_W+7:0] b;
    a = {{CNT_W{1'b0}}, v};
    b = {8'b0, cnt};
    return a < b;
  endfunction

endpackage

`default_nettype wire

@@ rtl/idafr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idafr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                      clk,
  input  wire logic                                      we,
  input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                          wdata,
  input  wire logic [((DEPTH > 2) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output      logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/idafr_free_list.sv @@
`timescale 1ns / 1ps
`default_nettype none

module idafr_free_list (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire idafr_pkg::fl_cmd_t cmd,
  output      idafr_pkg::fl_stat_t stat
);
  import idafr_pkg::*;

  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;
  logic [ID_W-1:0]  rd_id;

  function automatic logic [ID_W-1:0] wrap_inc(input logic [ID_W-1:0] p);
    return (p == ID_W'(MAX_IDS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign do_push = cmd.push && (count_r != CNT_W'(MAX_IDS));
  assign do_pop  = cmd.pop && (count_r != '0);

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (do_push) begin
      tail_nxt = wrap_inc(tail_r);
    end
    if (do_pop) begin
      head_nxt = wrap_inc(head_r);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  idafr_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_fifo_ram (
    .clk   (clk),
    .we    (do_push),
    .waddr (tail_r),
    .wdata (cmd.push_id),
    .raddr (head_r),
    .rdata (rd_id)
  );

  assign stat.nonempty = (count_r != '0);
  assign stat.head_id  = rd_id;

endmodule

`default_nettype wire

@@ rtl/id_allocator_fifo_recycle_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// channel | ports                         | payload
// in      | in_valid, in_ready, in_data   | in_item_t  (action, id)
// out     | out_valid, out_ready, out_data| out_item_t (id_out, live, status)
//
// allocate, release and query do one live map or free list read,
// then the write back and result load
// clear reads one live map entry per cycle below the issued count and frees each live one
// no clearing pass after reset: entries at or above the high-water count read as free
// a result waits in the output register; the next transaction is taken meanwhile
// and completes once that register has been emptied

module id_allocator_fifo_recycle_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output      logic                 in_ready,
  input  wire idafr_pkg::in_item_t  in_data,
  output      logic                 out_valid,
  input  wire logic                 out_ready,
  output      idafr_pkg::out_item_t out_data
);
  import idafr_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RD    = 4'b0010,
    S_SWEEP = 4'b0100,
    S_FIN   = 4'b1000
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       act_r, act_nxt;
  logic [7:0]       id_r, id_nxt;
  logic [CNT_W-1:0] issued_r, issued_nxt;
  logic [CNT_W-1:0] sw_r, sw_nxt;
  logic             chk_vld_r, chk_vld_nxt;
  logic [ID_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic             live_we;
  logic [ID_W-1:0]  live_waddr;
  logic             live_wdata;
  logic [ID_W-1:0]  live_raddr;
  logic             live_rdata;
  fl_cmd_t          fl_cmd;
  fl_stat_t         fl_stat;

  logic             out_free;
  logic             accept;
  logic             id_ok;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign id_ok    = id_below(id_r, issued_r);

  always_comb begin
    state_nxt     = state_r;
    act_nxt       = act_r;
    id_nxt        = id_r;
    issued_nxt    = issued_r;
    sw_nxt        = sw_r;
    chk_vld_nxt   = 1'b0;
    chk_idx_nxt   = chk_idx_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    live_we       = 1'b0;
    live_waddr    = '0;
    live_wdata    = 1'b0;
    live_raddr    = id8_to_addr(id_r);
    fl_cmd        = '0;

    case (state_r)
      S_IDLE: begin
        live_raddr = id8_to_addr(in_data.id);
        if (accept) begin
          act_nxt = in_data.action;
          id_nxt  = in_data.id;
          sw_nxt  = '0;
          if (in_data.action == ACT_CLEAR) begin
            state_nxt = S_SWEEP;
          end else begin
            state_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.id_out = id_r;
          out_data_nxt.live   = 1'b0;
          out_data_nxt.status = ST_OK;
          state_nxt           = S_IDLE;
          case (act_r)
            ACT_ALLOC: begin
              if (fl_stat.nonempty) begin
                live_we             = 1'b1;
                live_waddr          = fl_stat.head_id;
                live_wdata          = 1'b1;
                fl_cmd.pop          = 1'b1;
                out_data_nxt.id_out = addr_to_id8(fl_stat.head_id);
              end else if (issued_r != CNT_W'(MAX_IDS)) begin
                live_we             = 1'b1;
                live_waddr          = issued_r[ID_W-1:0];
                live_wdata          = 1'b1;
                issued_nxt          = issued_r + 1'b1;
                out_data_nxt.id_out = addr_to_id8(issued_r[ID_W-1:0]);
              end else begin
                out_data_nxt.id_out = '0;
                out_data_nxt.status = ST_FULL;
              end
            end
            ACT_RELEASE: begin
              if (id_ok && live_rdata) begin
                live_we        = 1'b1;
                live_waddr     = id8_to_addr(id_r);
                live_wdata     = 1'b0;
                fl_cmd.push    = 1'b1;
                fl_cmd.push_id = id8_to_addr(id_r);
              end else begin
                out_data_nxt.status = ST_BAD;
              end
            end
            ACT_QUERY: begin
              out_data_nxt.live = id_ok && live_rdata;
            end
            default: begin
              out_data_nxt.live = 1'b0;
            end
          endcase
        end
      end
      S_SWEEP: begin
        live_raddr = sw_r[ID_W-1:0];
        if (chk_vld_r && live_rdata) begin
          live_we        = 1'b1;
          live_waddr     = chk_idx_r;
          live_wdata     = 1'b0;
          fl_cmd.push    = 1'b1;
          fl_cmd.push_id = chk_idx_r;
        end
        if (sw_r < issued_r) begin
          chk_vld_nxt = 1'b1;
          chk_idx_nxt = sw_r[ID_W-1:0];
          sw_nxt      = sw_r + 1'b1;
        end else if (!chk_vld_r) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.id_out = id_r;
          out_data_nxt.live   = 1'b0;
          out_data_nxt.status = ST_OK;
          state_nxt           = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issued_r    <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      chk_vld_r   <= chk_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r      <= act_nxt;
    id_r       <= id_nxt;
    sw_r       <= sw_nxt;
    chk_idx_r  <= chk_idx_nxt;
    out_data_r <= out_data_nxt;
  end

  idafr_ram #(
    .WIDTH (1),
    .DEPTH (MAX_IDS)
  ) u_live_ram (
    .clk   (clk),
    .we    (live_we),
    .waddr (live_waddr),
    .wdata (live_wdata),
    .raddr (live_raddr),
    .rdata (live_rdata)
  );

  idafr_free_list u_free_list (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (fl_cmd),
    .stat  (fl_stat)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import idafr_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int ITEMS_PER_PHASE = 170;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  // allocator state as predicted
  bit         live_bits [MAX_IDS];
  int         high_water;
  logic [7:0] free_ids [$];

  out_item_t  pending_results [$];
  int         errors;
  int         in_idle_pct;
  int         out_idle_pct;
  int         stall_cycles;
  int         txn_count;
  int         full_hits;
  int         clear_count;
  int         release_ok;
  int         drain_left;

  id_allocator_fifo_recycle_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic out_item_t allocator_step(input in_item_t it);
    out_item_t  r;
    logic [7:0] v;
    r.id_out = it.id;
    r.live   = 1'b0;
    r.status = ST_OK;
    case (action_t'(it.action))
      ACT_ALLOC: begin
        if (free_ids.size() > 0) begin
          v = free_ids[0];
          free_ids.delete(0);
          live_bits[v] = 1'b1;
          r.id_out = v;
        end else if (high_water < MAX_IDS) begin
          live_bits[high_water] = 1'b1;
          r.id_out = 8'(high_water);
          high_water++;
        end else begin
          r.id_out = 8'd0;
          r.status = ST_FULL;
          full_hits++;
        end
      end
      ACT_RELEASE: begin
        if (int'(it.id) < high_water && live_bits[it.id]) begin
          live_bits[it.id] = 1'b0;
          free_ids = {free_ids, it.id};
          release_ok++;
        end else begin
          r.status = ST_BAD;
        end
      end
      ACT_QUERY: begin
        r.live = (int'(it.id) < high_water) && live_bits[it.id];
      end
      default: begin
        clear_count++;
        for (int i = 0; i < high_water; i++) begin
          if (live_bits[i]) begin
            live_bits[i] = 1'b0;
            free_ids = {free_ids, 8'(i)};
          end
        end
      end
    endcase
    return r;
  endfunction

  // mostly a live id, sometimes anything at all or a possibly dead one below the mark
  function automatic logic [7:0] pick_id();
    int roll;
    logic [7:0] v;
    roll = $urandom_range(99);
    if (high_water == 0 || roll < 15) return 8'($urandom_range(255));
    if (roll < 30) return 8'($urandom_range(high_water - 1));
    for (int k = 0; k < 8; k++) begin
      v = 8'($urandom_range(high_water - 1));
      if (live_bits[v]) return v;
    end
    return v;
  endfunction

  // fill mode runs the allocator to full, drain mode gives ids back
  function automatic in_item_t next_random_item();
    in_item_t it;
    int roll;
    roll = $urandom_range(99);
    it.id = 8'($urandom_range(255));
    if (drain_left > 0) begin
      drain_left--;
      if (roll < 15) it.action = ACT_ALLOC;
      else if (roll < 70) begin
        it.action = ACT_RELEASE;
        it.id = pick_id();
      end else if (roll < 92) begin
        it.action = ACT_QUERY;
        it.id = pick_id();
      end else it.action = ACT_CLEAR;
    end else begin
      if (roll < 86) it.action = ACT_ALLOC;
      else if (roll < 91) begin
        it.action = ACT_RELEASE;
        it.id = pick_id();
      end else if (roll < 99) begin
        it.action = ACT_QUERY;
        it.id = pick_id();
      end else it.action = ACT_CLEAR;
    end
    return it;
  endfunction

  // called and returning at a falling edge
  task automatic send_txn(input in_item_t it, input bit typed, input out_item_t want);
    out_item_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    r = allocator_step(it);
    pending_results = {pending_results, (typed ? want : r)};
    txn_count++;
    if (r.status == ST_FULL && drain_left == 0) drain_left = 60;
    @(negedge clk);
  endtask

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with none expected: id_out %0d live %0d status %0d",
               out_data.id_out, out_data.live, out_data.status);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_data.id_out !== want.id_out) begin
          $error("id_out: expected %0d, actual %0d", want.id_out, out_data.id_out);
          errors++;
        end
        if (out_data.live !== want.live) begin
          $error("live: expected %0d, actual %0d", want.live, out_data.live);
          errors++;
        end
        if (out_data.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
      $display("tb_top: done, errors");
      $finish;
    end
  end

  function automatic stim_row_t row(input action_t a, input logic [7:0] id, input bit typed,
                                    input logic [7:0] w_id, input logic w_live,
                                    input status_t w_st);
    stim_row_t s;
    s.it.action   = a;
    s.it.id       = id;
    s.typed       = typed;
    s.want.id_out = w_id;
    s.want.live   = w_live;
    s.want.status = w_st;
    return s;
  endfunction

  stim_row_t directed [$];

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    errors       = 0;
    high_water   = 0;
    stall_cycles = 0;
    txn_count    = 0;
    full_hits    = 0;
    clear_count  = 0;
    release_ok   = 0;
    drain_left   = 0;
    in_idle_pct  = 35;
    out_idle_pct = 67;

    directed = '{
      row(ACT_ALLOC,   8'h5a, 1, 8'd0,   1'b0, ST_OK),
      row(ACT_QUERY,   8'h00, 1, 8'd0,   1'b1, ST_OK),
      row(ACT_QUERY,   8'hff, 1, 8'd255, 1'b0, ST_OK),
      row(ACT_RELEASE, 8'h01, 1, 8'd1,   1'b0, ST_BAD),
      row(ACT_RELEASE, 8'hff, 1, 8'd255, 1'b0, ST_BAD),
      row(ACT_ALLOC,   8'hff, 1, 8'd1,   1'b0, ST_OK),
      row(ACT_ALLOC,   8'h00, 1, 8'd2,   1'b0, ST_OK),
      row(ACT_RELEASE, 8'h01, 1, 8'd1,   1'b0, ST_OK),
      row(ACT_RELEASE, 8'h01, 1, 8'd1,   1'b0, ST_BAD),
      row(ACT_QUERY,   8'h01, 1, 8'd1,   1'b0, ST_OK),
      row(ACT_RELEASE, 8'h00, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_ALLOC,   8'h33, 1, 8'd1,   1'b0, ST_OK),
      row(ACT_ALLOC,   8'hcc, 1, 8'd0,   1'b0, ST_OK),
      row(ACT_ALLOC,   8'h0f, 1, 8'd3,   1'b0, ST_OK),
      row(ACT_QUERY,   8'h02, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_CLEAR,   8'haa, 1, 8'haa,  1'b0, ST_OK),
      row(ACT_QUERY,   8'h03, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_CLEAR,   8'h55, 1, 8'h55,  1'b0, ST_OK),
      row(ACT_ALLOC,   8'hf0, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_RELEASE, 8'h00, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_ALLOC,   8'h80, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_QUERY,   8'h00, 0, 8'd0,   1'b0, ST_OK),
      row(ACT_RELEASE, 8'hfe, 1, 8'hfe,  1'b0, ST_BAD),
      row(ACT_ALLOC,   8'h7f, 0, 8'd0,   1'b0, ST_OK)
    };

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (directed[k]) send_txn(directed[k].it, directed[k].typed, directed[k].want);

    for (int phase = 0; phase < 3; phase++) begin
      in_idle_pct  = (phase == 0) ? 35 : (phase == 1) ? 67 : 0;
      out_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 35 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_txn(next_random_item(), 1'b0, '0);
      if (phase == 0) begin
        in_valid <= 1'b0;
        while (pending_results.size() > 0) @(negedge clk);
      end
    end
    in_valid <= 1'b0;

    while (pending_results.size() > 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("covered %0d transactions: %0d good releases, %0d clears, %0d allocations when full",
             txn_count, release_ok, clear_count, full_hits);
    $display("high-water mark reached %0d, under three sender/receiver idling mixes",
             high_water);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      if (pending_results.size() > 0)
        $error("%0d expected results never arrived", pending_results.size());
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
